// ===== sv/tlaik_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics: shared package
// Types, register indexes, status codes, widths and the arctangent table.
// ----------------------------------------------------------------------------
package tlaik_pkg;

    localparam int CORDIC_STAGES_DEFAULT   = 16;
    localparam int ANGLE_FRAC_BITS_DEFAULT = 7;

    localparam int INT_FRAC    = 20;
    localparam int COORD_W     = 16;
    localparam int LINK_W      = 15;
    localparam int HEIGHT_W    = 16;
    localparam int LIMIT_W     = 9;
    localparam int CFG_W       = 16;
    localparam int SQRT_W      = 62;
    localparam int SQRT_STEPS  = SQRT_W / 2;
    localparam int SQRT_SCALE  = 14;
    localparam int LANE_IN_W   = 48;
    localparam int NORM_STAGES = 16;
    localparam int NORM_BITS   = 32;
    localparam int DATA_W      = 56;
    localparam int ACC_W       = 32;
    localparam int HALF_TURN_DEG = 180;

    localparam logic signed [ACC_W-1:0] HALF_TURN = 32'sd188743680;

    localparam logic [LINK_W-1:0]          UPPER_LINK_RESET  = 15'd1600;
    localparam logic [LINK_W-1:0]          LOWER_LINK_RESET  = 15'd1600;
    localparam logic signed [HEIGHT_W-1:0] SHOULDER_RESET    = 16'sd0;
    localparam logic [LIMIT_W-1:0]         ANGLE_LIMIT_RESET = 9'd180;

    typedef enum logic [1:0] {
        REG_UPPER_LINK      = 2'd0,
        REG_LOWER_LINK      = 2'd1,
        REG_SHOULDER_HEIGHT = 2'd2,
        REG_ANGLE_LIMIT     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FAR   = 2'd1,
        STATUS_LIMIT = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } target_t;

    typedef struct packed {
        logic signed [15:0] shoulder_angle;
        logic [14:0]        elbow_angle;
        logic signed [15:0] base_angle;
        status_t            status;
    } result_t;

    // Arctangent of 2^-idx in units of 2^-20 degree.
    function automatic logic signed [ACC_W-1:0] atan_step(input int idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            0:       v = 32'sd47185920;
            1:       v = 32'sd27855475;
            2:       v = 32'sd14718068;
            3:       v = 32'sd7471121;
            4:       v = 32'sd3750058;
            5:       v = 32'sd1876857;
            6:       v = 32'sd938658;
            7:       v = 32'sd469357;
            8:       v = 32'sd234682;
            9:       v = 32'sd117342;
            10:      v = 32'sd58671;
            11:      v = 32'sd29335;
            12:      v = 32'sd14668;
            13:      v = 32'sd7334;
            14:      v = 32'sd3667;
            15:      v = 32'sd1833;
            16:      v = 32'sd917;
            17:      v = 32'sd458;
            18:      v = 32'sd229;
            19:      v = 32'sd115;
            20:      v = 32'sd57;
            21:      v = 32'sd29;
            22:      v = 32'sd14;
            23:      v = 32'sd7;
            24:      v = 32'sd4;
            25:      v = 32'sd2;
            26:      v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/tlaik_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the bitwise integer square root, registered.
// ----------------------------------------------------------------------------
module tlaik_sqrt_cell #(
    parameter int W   = tlaik_pkg::SQRT_W,
    parameter int BIT = 0
) (
    input  logic         clk,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] root_in,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] root_out
);

    localparam logic [W-1:0] B = W'(1) << BIT;

    logic [W-1:0] trial;
    logic [W-1:0] rem_next;
    logic [W-1:0] root_next;
    logic [W-1:0] rem_reg;
    logic [W-1:0] root_reg;

    assign trial = root_in + B;

    always_comb
    begin
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + B;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== sv/tlaik_sqrt.sv =====
// ----------------------------------------------------------------------------
// Square root chain
// Floor integer square root as a row of cells, one result bit per cell.
// ----------------------------------------------------------------------------
module tlaik_sqrt #(
    parameter int W = tlaik_pkg::SQRT_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [W-1:0]   radicand,
    output logic           out_valid,
    output logic [W/2-1:0] root
);

    localparam int STEPS = W / 2;

    logic [W-1:0] rem_w  [STEPS+1];
    logic [W-1:0] root_w [STEPS+1];
    logic         valid_reg [STEPS];

    assign rem_w[0]  = radicand;
    assign root_w[0] = '0;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        tlaik_sqrt_cell #(
            .W   (W),
            .BIT (W - 2 - 2 * k)
        ) u_cell (
            .clk      (clk),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STEPS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign root      = root_w[STEPS][W/2-1:0];

endmodule

// ===== sv/tlaik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered vectoring rotation by the arctangent of 2^-STEP.
// ----------------------------------------------------------------------------
module tlaik_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                 clk,
    input  logic signed [tlaik_pkg::DATA_W-1:0]  x_in,
    input  logic signed [tlaik_pkg::DATA_W-1:0]  y_in,
    input  logic signed [tlaik_pkg::ACC_W-1:0]   acc_in,
    output logic signed [tlaik_pkg::DATA_W-1:0]  x_out,
    output logic signed [tlaik_pkg::DATA_W-1:0]  y_out,
    output logic signed [tlaik_pkg::ACC_W-1:0]   acc_out
);

    localparam logic signed [tlaik_pkg::ACC_W-1:0] ATAN = tlaik_pkg::atan_step(STEP);

    logic signed [tlaik_pkg::DATA_W-1:0] xs;
    logic signed [tlaik_pkg::DATA_W-1:0] ys;
    logic signed [tlaik_pkg::DATA_W-1:0] x_next;
    logic signed [tlaik_pkg::DATA_W-1:0] y_next;
    logic signed [tlaik_pkg::ACC_W-1:0]  acc_next;
    logic signed [tlaik_pkg::DATA_W-1:0] x_reg;
    logic signed [tlaik_pkg::DATA_W-1:0] y_reg;
    logic signed [tlaik_pkg::ACC_W-1:0]  acc_reg;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;

    always_comb
    begin
        if (!y_in[tlaik_pkg::DATA_W-1])
        begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            acc_next = acc_in + ATAN;
        end
        else
        begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            acc_next = acc_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;

endmodule

// ===== sv/tlaik_cordic.sv =====
// ----------------------------------------------------------------------------
// CORDIC arctangent lane
// Range reduction by halving, half-plane fold, a row of rotation cells and a
// final clamp to half a turn.
// ----------------------------------------------------------------------------
module tlaik_cordic #(
    parameter int STAGES = tlaik_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [tlaik_pkg::LANE_IN_W-1:0] y_in,
    input  logic signed [tlaik_pkg::LANE_IN_W-1:0] x_in,
    output logic                                   out_valid,
    output logic signed [tlaik_pkg::ACC_W-1:0]     angle
);

    localparam int LIW     = tlaik_pkg::LANE_IN_W;
    localparam int DW      = tlaik_pkg::DATA_W;
    localparam int AW      = tlaik_pkg::ACC_W;
    localparam int NS      = tlaik_pkg::NORM_STAGES;
    localparam int LATENCY = NS + STAGES + 2;

    localparam logic signed [LIW-1:0] NORM_MAX =
        {{(LIW - tlaik_pkg::NORM_BITS){1'b0}}, {tlaik_pkg::NORM_BITS{1'b1}}};
    localparam logic signed [LIW-1:0] NORM_MIN = -NORM_MAX;

    logic signed [LIW-1:0] ny_src [NS];
    logic signed [LIW-1:0] nx_src [NS];
    logic                  nz_src [NS];
    logic signed [LIW-1:0] ny_reg [NS];
    logic signed [LIW-1:0] nx_reg [NS];
    logic                  nz_reg [NS];

    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [DW-1:0] px_next;
    logic signed [DW-1:0] py_next;
    logic signed [AW-1:0] pa_next;
    logic signed [DW-1:0] px_reg;
    logic signed [DW-1:0] py_reg;
    logic signed [AW-1:0] pa_reg;
    logic                 pz_reg;

    logic signed [DW-1:0] cx [STAGES+1];
    logic signed [DW-1:0] cy [STAGES+1];
    logic signed [AW-1:0] ca [STAGES+1];
    logic                 zf_reg [STAGES];

    logic signed [AW-1:0] angle_next;
    logic signed [AW-1:0] angle_reg;
    logic                 valid_reg [LATENCY];

    always_comb
    begin
        ny_src[0] = y_in;
        nx_src[0] = x_in;
        nz_src[0] = (x_in == '0) && (y_in == '0);
        for (int k = 1; k < NS; k++)
        begin
            ny_src[k] = ny_reg[k-1];
            nx_src[k] = nx_reg[k-1];
            nz_src[k] = nz_reg[k-1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_norm
        logic wide;

        assign wide = (ny_src[k] > NORM_MAX) || (ny_src[k] < NORM_MIN) ||
                      (nx_src[k] > NORM_MAX) || (nx_src[k] < NORM_MIN);

        always_ff @(posedge clk)
        begin
            ny_reg[k] <= wide ? (ny_src[k] >>> 1) : ny_src[k];
            nx_reg[k] <= wide ? (nx_src[k] >>> 1) : nx_src[k];
            nz_reg[k] <= nz_src[k];
        end
    end

    assign sx = DW'(nx_reg[NS-1]) <<< tlaik_pkg::INT_FRAC;
    assign sy = DW'(ny_reg[NS-1]) <<< tlaik_pkg::INT_FRAC;

    always_comb
    begin
        if (sx[DW-1])
        begin
            px_next = -sx;
            py_next = -sy;
            pa_next = sy[DW-1] ? -tlaik_pkg::HALF_TURN : tlaik_pkg::HALF_TURN;
        end
        else
        begin
            px_next = sx;
            py_next = sy;
            pa_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        pa_reg <= pa_next;
        pz_reg <= nz_reg[NS-1];
    end

    assign cx[0] = px_reg;
    assign cy[0] = py_reg;
    assign ca[0] = pa_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        tlaik_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk     (clk),
            .x_in    (cx[k]),
            .y_in    (cy[k]),
            .acc_in  (ca[k]),
            .x_out   (cx[k+1]),
            .y_out   (cy[k+1]),
            .acc_out (ca[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        zf_reg[0] <= pz_reg;
        for (int k = 1; k < STAGES; k++)
        begin
            zf_reg[k] <= zf_reg[k-1];
        end
    end

    always_comb
    begin
        if (zf_reg[STAGES-1])
        begin
            angle_next = '0;
        end
        else if (ca[STAGES] > tlaik_pkg::HALF_TURN)
        begin
            angle_next = tlaik_pkg::HALF_TURN;
        end
        else if (ca[STAGES] < -tlaik_pkg::HALF_TURN)
        begin
            angle_next = -tlaik_pkg::HALF_TURN;
        end
        else
        begin
            angle_next = ca[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LATENCY; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < LATENCY; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[LATENCY-1];
    assign angle     = angle_reg;

endmodule

// ===== sv/two_link_arm_inverse_kinematics_core.sv =====
// ----------------------------------------------------------------------------
// Two-link arm inverse kinematics core
// The pipeline runs through the 31-cell square root chain and the four CORDIC
// lanes of 16 range cells plus CORDIC_STAGES rotation cells.
// Throughput: one command per clock cycle; busy stays low.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics_core #(
    parameter int CORDIC_STAGES   = tlaik_pkg::CORDIC_STAGES_DEFAULT,
    parameter int ANGLE_FRAC_BITS = tlaik_pkg::ANGLE_FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tlaik_pkg::target_t              target,
    output logic                            done,
    output tlaik_pkg::result_t              result,
    input  logic                            wr_en,
    input  tlaik_pkg::reg_index_t           wr_index,
    input  logic [tlaik_pkg::CFG_W-1:0]     wr_data
);

    localparam int LIW     = tlaik_pkg::LANE_IN_W;
    localparam int AW      = tlaik_pkg::ACC_W;
    localparam int RW      = AW + 1;
    localparam int LW      = tlaik_pkg::LINK_W;
    localparam int SW      = tlaik_pkg::SQRT_W;
    localparam int STEPS   = tlaik_pkg::SQRT_STEPS;
    localparam int CLAT    = tlaik_pkg::NORM_STAGES + CORDIC_STAGES + 2;
    localparam int LATENCY = CLAT + 40;
    localparam int SH      = tlaik_pkg::INT_FRAC - ANGLE_FRAC_BITS;

    localparam logic [RW-1:0]        ROUND_HALF = RW'(1) << (SH - 1);
    localparam logic signed [RW-1:0] FULL =
        $signed(RW'(tlaik_pkg::HALF_TURN_DEG) << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] h;
        logic signed [31:0] num;
        logic signed [47:0] betax;
        logic               oor;
    } side_t;

    // Configuration registers.
    logic [LW-1:0]                upper_link_reg;
    logic [LW-1:0]                lower_link_reg;
    logic signed [15:0]           shoulder_height_reg;
    logic [tlaik_pkg::LIMIT_W-1:0] angle_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_link_reg      <= tlaik_pkg::UPPER_LINK_RESET;
            lower_link_reg      <= tlaik_pkg::LOWER_LINK_RESET;
            shoulder_height_reg <= tlaik_pkg::SHOULDER_RESET;
            angle_limit_reg     <= tlaik_pkg::ANGLE_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tlaik_pkg::REG_UPPER_LINK:      upper_link_reg <= wr_data[LW-1:0];
                tlaik_pkg::REG_LOWER_LINK:      lower_link_reg <= wr_data[LW-1:0];
                tlaik_pkg::REG_SHOULDER_HEIGHT: shoulder_height_reg <= $signed(wr_data);
                tlaik_pkg::REG_ANGLE_LIMIT:
                    angle_limit_reg <= wr_data[tlaik_pkg::LIMIT_W-1:0];
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits of the front and final stages.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vf1_reg, done_reg;

    // Stage 1: command capture.
    logic signed [15:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge clk)
    begin
        x1_reg <= target.target_x;
        y1_reg <= target.target_y;
        z1_reg <= target.target_z;
    end

    // Stage 2: squares and link products.
    logic signed [16:0] h_full;
    logic signed [31:0] xx_full, yy_full;
    logic signed [33:0] hh_full;
    logic [29:0]        l1sq_full, l2sq_full, l1l2_full;
    logic [15:0]        lsum;
    logic [31:0]        sum2_full;
    logic signed [15:0] ldif;
    logic signed [31:0] dif_full;

    assign h_full    = {z1_reg[15], z1_reg} - {shoulder_height_reg[15], shoulder_height_reg};
    assign xx_full   = x1_reg * x1_reg;
    assign yy_full   = y1_reg * y1_reg;
    assign hh_full   = h_full * h_full;
    assign l1sq_full = upper_link_reg * upper_link_reg;
    assign l2sq_full = lower_link_reg * lower_link_reg;
    assign l1l2_full = upper_link_reg * lower_link_reg;
    assign lsum      = {1'b0, upper_link_reg} + {1'b0, lower_link_reg};
    assign sum2_full = lsum * lsum;
    assign ldif      = $signed({1'b0, upper_link_reg}) - $signed({1'b0, lower_link_reg});
    assign dif_full  = ldif * ldif;

    logic signed [15:0] x2_reg, y2_reg;
    logic signed [16:0] h2_reg;
    logic [30:0]        xx2_reg, yy2_reg;
    logic [31:0]        hh2_reg, sum2_2_reg;
    logic [29:0]        l1sq2_reg, l2sq2_reg, l1l2_2_reg, dif2_2_reg;

    always_ff @(posedge clk)
    begin
        x2_reg     <= x1_reg;
        y2_reg     <= y1_reg;
        h2_reg     <= h_full;
        xx2_reg    <= xx_full[30:0];
        yy2_reg    <= yy_full[30:0];
        hh2_reg    <= hh_full[31:0];
        l1sq2_reg  <= l1sq_full;
        l2sq2_reg  <= l2sq_full;
        l1l2_2_reg <= l1l2_full;
        sum2_2_reg <= sum2_full;
        dif2_2_reg <= dif_full[29:0];
    end

    // Stage 3: sums.
    logic signed [15:0] x3_reg, y3_reg;
    logic signed [16:0] h3_reg;
    logic [31:0]        w2_3_reg, sum2_3_reg;
    logic [33:0]        r2_3_reg;
    logic [30:0]        lsq3_reg, den3_reg;
    logic [29:0]        dif2_3_reg;

    always_ff @(posedge clk)
    begin
        x3_reg     <= x2_reg;
        y3_reg     <= y2_reg;
        h3_reg     <= h2_reg;
        w2_3_reg   <= {1'b0, xx2_reg} + {1'b0, yy2_reg};
        r2_3_reg   <= 34'(xx2_reg) + 34'(yy2_reg) + 34'(hh2_reg);
        lsq3_reg   <= 31'(l1sq2_reg) + 31'(l2sq2_reg);
        den3_reg   <= {l1l2_2_reg, 1'b0};
        sum2_3_reg <= sum2_2_reg;
        dif2_3_reg <= dif2_2_reg;
    end

    // Stage 4: cosine numerator and reach test.
    logic signed [34:0] num_full;

    assign num_full = $signed({1'b0, r2_3_reg}) - $signed({4'b0, lsq3_reg});

    logic signed [15:0] x4_reg, y4_reg;
    logic signed [16:0] h4_reg;
    logic [31:0]        w2_4_reg;
    logic signed [31:0] num4_reg;
    logic [30:0]        den4_reg;
    logic               oor4_reg;

    always_ff @(posedge clk)
    begin
        x4_reg   <= x3_reg;
        y4_reg   <= y3_reg;
        h4_reg   <= h3_reg;
        w2_4_reg <= w2_3_reg;
        num4_reg <= num_full[31:0];
        den4_reg <= den3_reg;
        oor4_reg <= (r2_3_reg > 34'(sum2_3_reg)) || (r2_3_reg < 34'(dif2_3_reg));
    end

    // Stage 5: products for the sine term and the shoulder correction.
    logic [61:0]        dd_full;
    logic signed [63:0] nn_full;
    logic [45:0]        l1den_full;
    logic signed [46:0] l2num_full;

    assign dd_full    = den4_reg * den4_reg;
    assign nn_full    = num4_reg * num4_reg;
    assign l1den_full = upper_link_reg * den4_reg;
    assign l2num_full = $signed({1'b0, lower_link_reg}) * num4_reg;

    logic signed [15:0] x5_reg, y5_reg;
    logic signed [16:0] h5_reg;
    logic [31:0]        w2_5_reg;
    logic signed [31:0] num5_reg;
    logic               oor5_reg;
    logic [61:0]        dd5_reg, nn5_reg;
    logic [45:0]        l1den5_reg;
    logic signed [46:0] l2num5_reg;

    always_ff @(posedge clk)
    begin
        x5_reg     <= x4_reg;
        y5_reg     <= y4_reg;
        h5_reg     <= h4_reg;
        w2_5_reg   <= w2_4_reg;
        num5_reg   <= num4_reg;
        oor5_reg   <= oor4_reg;
        dd5_reg    <= dd_full;
        nn5_reg    <= nn_full[61:0];
        l1den5_reg <= l1den_full;
        l2num5_reg <= l2num_full;
    end

    // Stage 6: square root operands.
    logic [SW-1:0] dn6_reg;
    logic [SW-1:0] wsq6_reg;
    side_t         side6_reg;

    always_ff @(posedge clk)
    begin
        dn6_reg         <= dd5_reg - nn5_reg;
        wsq6_reg        <= SW'(w2_5_reg) << (2 * tlaik_pkg::SQRT_SCALE);
        side6_reg.x     <= x5_reg;
        side6_reg.y     <= y5_reg;
        side6_reg.h     <= h5_reg;
        side6_reg.num   <= num5_reg;
        side6_reg.betax <= $signed({2'b0, l1den5_reg}) + 48'(l2num5_reg);
        side6_reg.oor   <= oor5_reg;
    end

    // Square roots, with the other operands riding alongside.
    logic              sq_valid;
    logic [SW/2-1:0]   s_root;
    logic [SW/2-1:0]   wq_root;
    side_t             side_reg [STEPS];

    tlaik_sqrt #(
        .W (SW)
    ) u_sqrt_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .radicand  (dn6_reg),
        .out_valid (sq_valid),
        .root      (s_root)
    );

    tlaik_sqrt #(
        .W (SW)
    ) u_sqrt_reach (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .radicand  (wsq6_reg),
        .out_valid (),
        .root      (wq_root)
    );

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side6_reg;
        for (int k = 1; k < STEPS; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Stage 7: CORDIC lane operands.
    side_t          side_q;
    logic [45:0]    l2s_full;

    assign side_q   = side_reg[STEPS-1];
    assign l2s_full = lower_link_reg * s_root;

    logic signed [LIW-1:0] ay_reg, ax_reg, by_reg, bx_reg, ey_reg, ex_reg, zy_reg, zx_reg;
    logic                  oor7_reg;

    always_ff @(posedge clk)
    begin
        ay_reg   <= LIW'(side_q.h) <<< tlaik_pkg::SQRT_SCALE;
        ax_reg   <= $signed({{(LIW - SW / 2){1'b0}}, wq_root});
        by_reg   <= $signed({2'b0, l2s_full});
        bx_reg   <= side_q.betax;
        ey_reg   <= $signed({{(LIW - SW / 2){1'b0}}, s_root});
        ex_reg   <= LIW'(side_q.num);
        zy_reg   <= LIW'(side_q.y);
        zx_reg   <= LIW'(side_q.x);
        oor7_reg <= side_q.oor;
    end

    logic                 lane_valid;
    logic signed [AW-1:0] alpha, beta, elbow_i, base_i;

    tlaik_cordic #(.STAGES (CORDIC_STAGES)) u_lane_alpha (
        .clk (clk), .rst_n (rst_n), .in_valid (v7_reg),
        .y_in (ay_reg), .x_in (ax_reg), .out_valid (lane_valid), .angle (alpha)
    );

    tlaik_cordic #(.STAGES (CORDIC_STAGES)) u_lane_beta (
        .clk (clk), .rst_n (rst_n), .in_valid (v7_reg),
        .y_in (by_reg), .x_in (bx_reg), .out_valid (), .angle (beta)
    );

    tlaik_cordic #(.STAGES (CORDIC_STAGES)) u_lane_elbow (
        .clk (clk), .rst_n (rst_n), .in_valid (v7_reg),
        .y_in (ey_reg), .x_in (ex_reg), .out_valid (), .angle (elbow_i)
    );

    tlaik_cordic #(.STAGES (CORDIC_STAGES)) u_lane_base (
        .clk (clk), .rst_n (rst_n), .in_valid (v7_reg),
        .y_in (zy_reg), .x_in (zx_reg), .out_valid (), .angle (base_i)
    );

    logic oor_line_reg [CLAT];

    always_ff @(posedge clk)
    begin
        oor_line_reg[0] <= oor7_reg;
        for (int k = 1; k < CLAT; k++)
        begin
            oor_line_reg[k] <= oor_line_reg[k-1];
        end
    end

    // Final stage 1: rounding to the output scale.
    function automatic logic signed [RW-1:0] to_out(input logic signed [RW-1:0] a);
        logic [RW-1:0] mag;
        logic [RW-1:0] q;
        mag = a[RW-1] ? $unsigned(-a) : $unsigned(a);
        q   = (mag + ROUND_HALF) >> SH;
        return a[RW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [RW-1:0] sat(input logic signed [RW-1:0] v,
                                                 input logic signed [RW-1:0] lo,
                                                 input logic signed [RW-1:0] hi);
        logic signed [RW-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic signed [RW-1:0] sh_f1_reg, el_f1_reg, ba_f1_reg;
    logic                 oor_f1_reg;

    always_ff @(posedge clk)
    begin
        sh_f1_reg  <= to_out(RW'(alpha) + RW'(beta));
        el_f1_reg  <= to_out(RW'(elbow_i));
        ba_f1_reg  <= to_out(RW'(base_i));
        oor_f1_reg <= oor_line_reg[CLAT-1];
    end

    // Final stage 2: limit test, saturation and result register.
    logic signed [RW-1:0] lim;
    logic                 in_limit;
    logic signed [RW-1:0] sh_sat, el_sat, ba_sat;
    tlaik_pkg::result_t   result_next;
    tlaik_pkg::result_t   result_reg;

    assign lim = $signed(RW'(angle_limit_reg) << ANGLE_FRAC_BITS);

    always_comb
    begin
        in_limit = !sh_f1_reg[RW-1] && (sh_f1_reg <= lim) &&
                   !el_f1_reg[RW-1] && (el_f1_reg <= lim) &&
                   !ba_f1_reg[RW-1] && (ba_f1_reg <= lim);
        sh_sat = sat(sh_f1_reg, -FULL, FULL);
        el_sat = sat(el_f1_reg, '0, FULL);
        ba_sat = sat(ba_f1_reg, -FULL, FULL);
        if (oor_f1_reg)
        begin
            result_next.shoulder_angle = '0;
            result_next.elbow_angle    = '0;
            result_next.base_angle     = '0;
            result_next.status         = tlaik_pkg::STATUS_FAR;
        end
        else
        begin
            result_next.shoulder_angle = sh_sat[15:0];
            result_next.elbow_angle    = el_sat[14:0];
            result_next.base_angle     = ba_sat[15:0];
            result_next.status = in_limit ? tlaik_pkg::STATUS_OK : tlaik_pkg::STATUS_LIMIT;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            vf1_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= sq_valid;
            vf1_reg  <= lane_valid;
            done_reg <= vf1_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result beat has a matching earlier command.
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching command");

    a_cmd_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("command produced no result beat");

    a_far_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == tlaik_pkg::STATUS_FAR) |->
        (result.shoulder_angle == '0 && result.elbow_angle == '0 &&
         result.base_angle == '0))
        else $error("unreachable target with nonzero angles");

endmodule
